// ===== hw/rtl/sorted_timestamp_set_macros.svh =====
// Assertion macros for the sorted time stamp set.
// No dependencies; the asserting modules include this file.
`ifndef SORTED_TIMESTAMP_SET_MACROS_SVH
`define SORTED_TIMESTAMP_SET_MACROS_SVH

`ifndef ASSERT_OFF
`define STS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STS_ASSERT(label, prop, msg)
`define STS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/sts_pkg.sv =====
// Shared types and constants of the sorted time stamp set.
// No dependencies.
package sts_pkg;

  localparam int POS_BITS   = 6;
  localparam int COUNT_BITS = 7;
  localparam int OUT_STAMP_BITS = 32;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_NEAR   = 3'd4,
    CMD_BEFORE = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEL,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sts_cell.sv =====
// One cell of the stamp chain: holds one stamp and its compare flags.
// Depends on sts_pkg.
module sts_cell import sts_pkg::*; #(
  parameter int SW    = 32,
  parameter int CNTW  = 7,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [SW-1:0]      cmp_stamp,
  input  logic [SW-1:0]      ins_stamp,
  input  logic [CNTW-1:0]    count,
  input  logic [POS_BITS-1:0] rm_pos,
  input  logic [SW-1:0]      prev_val,
  input  logic               prev_lt,
  input  logic [SW-1:0]      next_val,
  input  logic               next_lt,
  output logic [SW-1:0]      val,
  output logic               lt,
  output logic               eq,
  output logic               first,
  output logic               last_lt
);

  logic          valid;
  logic [SW-1:0] val_next;

  assign valid = INDEX < int'(count);

  always_comb begin
    val_next = val;
    case (ctrl.op)
      OP_INSERT: begin
        if (!lt) begin
          val_next = prev_lt ? ins_stamp : prev_val;
        end
      end
      OP_REMOVE: begin
        if (INDEX >= int'(rm_pos)) begin
          val_next = next_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (ctrl.capture) begin
      lt <= valid && (val < cmp_stamp);
      eq <= valid && (val == cmp_stamp);
    end
  end

  assign first   = !lt && prev_lt;
  assign last_lt = lt && !next_lt;

endmodule

// ===== hw/rtl/sts_select.sv =====
// Registered selection of predecessor, successor, addressed stamp and lower bound.
// Depends on sts_pkg.
module sts_select import sts_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int SW       = 32,
  parameter int CNTW     = 7
) (
  input  logic                clk,
  input  logic                en,
  input  logic [SW-1:0]       vals [CAPACITY],
  input  logic [CAPACITY-1:0] first,
  input  logic [CAPACITY-1:0] last_lt,
  input  logic [CAPACITY-1:0] eq,
  input  logic [POS_BITS-1:0] pos,
  output logic [SW-1:0]       pred_v,
  output logic [SW-1:0]       succ_v,
  output logic [SW-1:0]       read_v,
  output logic [CNTW-1:0]     lo,
  output logic                exact
);

  logic [SW-1:0]   pred_c, succ_c, read_c;
  logic [CNTW-1:0] lo_c;

  always_comb begin
    pred_c = '0;
    succ_c = '0;
    read_c = '0;
    lo_c   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last_lt[i]) pred_c = pred_c | vals[i];
      if (first[i]) begin
        succ_c = succ_c | vals[i];
        lo_c   = lo_c | CNTW'(i);
      end
      if (i == int'(pos)) read_c = read_c | vals[i];
    end
    if (last_lt[CAPACITY-1]) lo_c = CNTW'(CAPACITY);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pred_v <= pred_c;
      succ_v <= succ_c;
      read_v <= read_c;
      lo     <= lo_c;
      exact  <= |eq;
    end
  end

endmodule

// ===== hw/rtl/sorted_timestamp_set.sv =====
// Sorted time stamp set: a chain of compare-and-shift cells with a registered selector.
// Each command is compared on acceptance, then selected, then applied in the update step.
// No new command is taken until the last result is loaded; a stalled output holds the load.
// Reset: rst (synchronous) empties the set and drops any pending result; stamps keep garbage.
`include "sorted_timestamp_set_macros.svh"
module sorted_timestamp_set import sts_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // stamp[31:0], position[37:32], zero pad
  input  logic [2:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_stamp[31:0], found_position[37:32],
                                      // stored_count[44:38], zero pad
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int SW   = (STAMP_BITS < OUT_STAMP_BITS) ? STAMP_BITS : OUT_STAMP_BITS;
  localparam int CNTW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  cmd_t                cmd_q;
  logic [SW-1:0]       t_q;
  logic [POS_BITS-1:0] pos_q;
  logic [CNTW-1:0]     count, count_next;

  logic [SW-1:0]       vals [CAPACITY];
  logic [CAPACITY-1:0] lt, eq, first, last_lt;
  cell_ctrl_t          ctrl;

  logic [SW-1:0]   pred_v, succ_v, read_v;
  logic [CNTW-1:0] lo;
  logic            exact;

  status_t         res_status;
  logic [SW-1:0]   res_stamp;
  logic [CNTW-1:0] res_pos;
  cell_op_t        res_op;
  logic [SW-1:0]   below, above;
  logic            pos_ok, full, accept, load, sel_en;

  logic                      out_valid;
  status_t                   out_status;
  logic [OUT_STAMP_BITS-1:0] out_stamp;
  logic [POS_BITS-1:0]       out_pos;
  logic [COUNT_BITS-1:0]     out_count;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign load   = (state == S_FIN) && (!out_valid || m_axis_tready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SEL;
      S_SEL:   state_next = S_FIN;
      S_FIN:   if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    sel_en        = 1'b0;
    case (state)
      S_IDLE:  s_axis_tready = 1'b1;
      S_SEL:   sel_en = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        sel_en        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(s_axis_tuser);
      t_q   <= s_axis_tdata[SW-1:0];
      pos_q <= s_axis_tdata[OUT_STAMP_BITS +: POS_BITS];
    end
  end

  assign ctrl.capture = accept;
  assign ctrl.op      = load ? res_op : OP_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] prev_val, next_val;
    logic          prev_lt, next_lt;
    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_lt  = 1'b1;
    end else begin : g_link_prev
      assign prev_val = vals[i-1];
      assign prev_lt  = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = vals[i];
      assign next_lt  = 1'b0;
    end else begin : g_link_next
      assign next_val = vals[i+1];
      assign next_lt  = lt[i+1];
    end
    sts_cell #(
      .SW(SW), .CNTW(CNTW), .INDEX(i)
    ) u_cell (
      .clk(clk), .ctrl(ctrl),
      .cmp_stamp(s_axis_tdata[SW-1:0]), .ins_stamp(t_q),
      .count(count), .rm_pos(pos_q),
      .prev_val(prev_val), .prev_lt(prev_lt),
      .next_val(next_val), .next_lt(next_lt),
      .val(vals[i]), .lt(lt[i]), .eq(eq[i]),
      .first(first[i]), .last_lt(last_lt[i])
    );
  end

  sts_select #(
    .CAPACITY(CAPACITY), .SW(SW), .CNTW(CNTW)
  ) u_select (
    .clk(clk), .en(sel_en), .vals(vals),
    .first(first), .last_lt(last_lt), .eq(eq), .pos(pos_q),
    .pred_v(pred_v), .succ_v(succ_v), .read_v(read_v),
    .lo(lo), .exact(exact)
  );

  assign below  = t_q - pred_v;
  assign above  = succ_v - t_q;
  assign pos_ok = int'(pos_q) < int'(count);
  assign full   = count == CNTW'(CAPACITY);

  always_comb begin
    res_status = ST_OK;
    res_stamp  = '0;
    res_pos    = '0;
    res_op     = OP_HOLD;
    count_next = count;
    case (cmd_q)
      CMD_INSERT: begin
        if (exact) begin
          res_stamp = t_q;
          res_pos   = lo;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_op     = OP_INSERT;
          count_next = count + CNTW'(1);
          res_stamp  = t_q;
          res_pos    = lo;
        end
      end
      CMD_REMOVE: begin
        if (!pos_ok) begin
          res_status = ST_RANGE;
        end else begin
          res_op     = OP_REMOVE;
          count_next = count - CNTW'(1);
          res_stamp  = read_v;
          res_pos    = CNTW'(pos_q);
        end
      end
      CMD_FIND: begin
        if (exact) begin
          res_stamp = t_q;
          res_pos   = lo;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          res_status = ST_RANGE;
        end else begin
          res_stamp = read_v;
          res_pos   = CNTW'(pos_q);
        end
      end
      CMD_NEAR: begin
        if (count == '0) begin
          res_status = ST_NOT_FOUND;
        end else if (exact) begin
          res_stamp = t_q;
          res_pos   = lo;
        end else if (lo == '0) begin
          res_stamp = succ_v;
        end else if (lo == count) begin
          res_stamp = pred_v;
          res_pos   = count - CNTW'(1);
        end else if (above < below) begin
          res_stamp = succ_v;
          res_pos   = lo;
        end else begin
          res_stamp = pred_v;
          res_pos   = lo - CNTW'(1);
        end
      end
      CMD_BEFORE: begin
        if (exact) begin
          res_stamp = t_q;
          res_pos   = lo;
        end else if (lo == '0) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_stamp = pred_v;
          res_pos   = lo - CNTW'(1);
        end
      end
      CMD_CLEAR: count_next = '0;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_stamp  <= OUT_STAMP_BITS'(res_stamp);
      out_pos    <= POS_BITS'(res_pos);
      out_count  <= COUNT_BITS'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {3'b000, out_count, out_pos, out_stamp};

  `STS_ASSERT(a_count_max, count <= CNTW'(CAPACITY), "count beyond capacity")
  `STS_ASSERT(a_accept_sel, accept |=> state == S_SEL, "accepted word not in select")
  `STS_ASSERT(a_load_valid, load |=> m_axis_tvalid, "loaded result not presented")
  `STS_ASSERT(a_count_hold, (state != S_FIN) |=> count == $past(count), "count moved off update")
  `STS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !m_axis_tvalid), "reset not idle")

endmodule

// ===== test/tb_sorted_timestamp_set.sv =====
// Self-checking testbench for the sorted time stamp set, driven over its stream ports.
// Needs sts_pkg and sorted_timestamp_set; a directed table runs first, then random traffic.
// Each result word is checked against an in-bench model, or against the table row's own outcome.
module tb_sorted_timestamp_set;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int SET_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1860;
  localparam logic [2:0] CMD_SPARE = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [31:0] stamp;
    logic [5:0]  pos;
    logic [6:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ts;
    logic [5:0]  idx;
    logic        checked;
    outcome_t    want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // stamp[31:0], position[37:32], zero pad
  logic [2:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // found_stamp[31:0], found_position[37:32],
                                    // stored_count[44:38], zero pad
  logic [1:0]  m_axis_tuser;        // status

  logic [31:0] held_stamps [SET_DEPTH] = '{default: '0};
  int          held_count = 0;
  outcome_t    pending_results [$];
  row_t        dir_rows [$];
  int          bad_results = 0;
  int          results_seen = 0;
  bit          calm = 1'b0;
  bit          cur_checked = 1'b0;
  outcome_t    cur_want = '0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  sorted_timestamp_set dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic outcome_t apply_command(input logic [2:0] op, input logic [31:0] ts,
                                             input logic [5:0] idx);
    outcome_t    r;
    int          below;
    bit          hit;
    logic [31:0] gone;
    logic [31:0] dlo;
    logic [31:0] dhi;
    below = 0;
    for (int i = 0; i < held_count; i++)
      if (held_stamps[i] < ts) below++;
    hit = (below < held_count) && (held_stamps[below] == ts);
    r.status = ST_OK;
    r.stamp  = '0;
    r.pos    = '0;
    case (op)
      CMD_INSERT: begin
        if (hit) begin
          r.stamp = ts;
          r.pos   = 6'(below);
        end else if (held_count >= SET_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held_count; i > below; i--) held_stamps[i] = held_stamps[i-1];
          held_stamps[below] = ts;
          held_count++;
          r.stamp = ts;
          r.pos   = 6'(below);
        end
      end
      CMD_REMOVE: begin
        if (idx >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          gone = held_stamps[idx];
          for (int i = idx; i + 1 < held_count; i++) held_stamps[i] = held_stamps[i+1];
          held_count--;
          r.stamp = gone;
          r.pos   = idx;
        end
      end
      CMD_FIND: begin
        if (hit) begin
          r.stamp = ts;
          r.pos   = 6'(below);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (idx >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          r.stamp = held_stamps[idx];
          r.pos   = idx;
        end
      end
      CMD_NEAR: begin
        if (held_count == 0) begin
          r.status = ST_NOT_FOUND;
        end else if (hit) begin
          r.stamp = ts;
          r.pos   = 6'(below);
        end else if (below == 0) begin
          r.stamp = held_stamps[0];
        end else if (below >= held_count) begin
          r.stamp = held_stamps[held_count-1];
          r.pos   = 6'(held_count - 1);
        end else begin
          dlo = ts - held_stamps[below-1];
          dhi = held_stamps[below] - ts;
          if (dhi < dlo) begin
            r.stamp = held_stamps[below];
            r.pos   = 6'(below);
          end else begin
            r.stamp = held_stamps[below-1];
            r.pos   = 6'(below - 1);
          end
        end
      end
      CMD_BEFORE: begin
        if (hit) begin
          r.stamp = ts;
          r.pos   = 6'(below);
        end else if (below == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.stamp = held_stamps[below-1];
          r.pos   = 6'(below - 1);
        end
      end
      CMD_CLEAR: held_count = 0;
      default: ;
    endcase
    r.count = 7'(held_count);
    return r;
  endfunction

  function automatic logic [2:0] pick_cmd(input int mode);
    int roll;
    int ins;
    int rem;
    roll = $urandom_range(0, 99);
    ins  = (mode == 0) ? 60 : (mode == 1) ? 30 : 15;
    rem  = (mode == 2) ? 45 : 15;
    if (roll == 99) return CMD_SPARE;
    if (roll == 98) return CMD_CLEAR;
    if (roll < ins) return CMD_INSERT;
    if (roll < ins + rem) return CMD_REMOVE;
    case (roll % 4)
      0: return CMD_FIND;
      1: return CMD_READ;
      2: return CMD_NEAR;
      default: return CMD_BEFORE;
    endcase
  endfunction

  function automatic logic [31:0] pick_stamp();
    logic [31:0] a;
    logic [32:0] sum;
    int          j;
    j = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
    a = held_stamps[j];
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 511);
      3, 4:    return a + $urandom_range(0, 6) - 3;
      5:       return a;
      6, 7:    return $urandom;
      8: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          4: return 32'hFFFF_FFFE;
          default: return $urandom_range(0, 15) << 16;
        endcase
      end
      default: begin
        if (j + 1 < held_count) begin
          sum = {1'b0, a} + {1'b0, held_stamps[j+1]};
          return sum[32:1];
        end
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [5:0] pick_pos();
    int hi;
    hi = (held_count > 63) ? 63 : held_count;
    if ($urandom_range(0, 3) != 0) return 6'($urandom_range(0, hi));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [31:0] ts, input logic [5:0] idx,
                         input logic checked, input status_t st, input logic [31:0] fs,
                         input logic [5:0] fp, input logic [6:0] fc);
    row_t r;
    r.op           = op;
    r.ts           = ts;
    r.idx          = idx;
    r.checked      = checked;
    r.want.status  = st;
    r.want.stamp   = fs;
    r.want.pos     = fp;
    r.want.count   = fc;
    dir_rows = {dir_rows, r};
  endtask

  // caller stands at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic [2:0] op, input logic [31:0] ts, input logic [5:0] idx,
                      input logic checked, input outcome_t want);
    while (!calm && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, idx, ts};
    s_axis_tuser  = op;
    cur_checked   = checked;
    cur_want      = want;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic report_bad(input string what, input outcome_t want, input outcome_t got);
    if (bad_results < 10)
      $display("%s: want st=%0d stamp=%h pos=%0d cnt=%0d, got st=%0d stamp=%h pos=%0d cnt=%0d",
               what, want.status, want.stamp, want.pos, want.count,
               got.status, got.stamp, got.pos, got.count);
    bad_results++;
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_t'(m_axis_tuser);
        got.stamp  = m_axis_tdata[31:0];
        got.pos    = m_axis_tdata[37:32];
        got.count  = m_axis_tdata[44:38];
        results_seen++;
        if (pending_results.size() == 0) begin
          report_bad("unexpected word", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.stamp !== want.stamp ||
              got.pos !== want.pos || got.count !== want.count)
            report_bad("mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[37:32]);
        if (cur_checked) want = cur_want;
        pending_results = {pending_results, want};
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 400) begin
      hold_done     = 1'b1;
      hold_left     = 300;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = calm || ($urandom_range(0, 99) >= 17);
    end
  end

  initial begin
    int         n;
    int         mode;
    logic [2:0] op;
    mode = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(CMD_FIND,   32'h0000_0000, 6'd0,  1, ST_NOT_FOUND, 32'h0, 6'd0, 7'd0);
    add_row(CMD_NEAR,   32'h0000_0005, 6'd63, 1, ST_NOT_FOUND, 32'h0, 6'd0, 7'd0);
    add_row(CMD_BEFORE, 32'h0000_0005, 6'd0,  1, ST_NOT_FOUND, 32'h0, 6'd0, 7'd0);
    add_row(CMD_READ,   32'hFFFF_FFFF, 6'd0,  1, ST_RANGE,     32'h0, 6'd0, 7'd0);
    add_row(CMD_REMOVE, 32'h0000_0000, 6'd63, 1, ST_RANGE,     32'h0, 6'd0, 7'd0);
    add_row(CMD_INSERT, 32'h0000_0000, 6'd0,  1, ST_OK, 32'h0000_0000, 6'd0, 7'd1);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 6'd63, 1, ST_OK, 32'hFFFF_FFFF, 6'd1, 7'd2);
    add_row(CMD_INSERT, 32'h0000_0000, 6'd0,  1, ST_OK, 32'h0000_0000, 6'd0, 7'd2);
    add_row(CMD_INSERT, 32'h0001_0000, 6'd0,  1, ST_OK, 32'h0001_0000, 6'd1, 7'd3);
    add_row(CMD_INSERT, 32'h0003_0000, 6'd0,  1, ST_OK, 32'h0003_0000, 6'd2, 7'd4);
    add_row(CMD_NEAR,   32'h0002_0000, 6'd0,  1, ST_OK, 32'h0001_0000, 6'd1, 7'd4);
    add_row(CMD_NEAR,   32'h0002_0001, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_NEAR,   32'h0003_0000, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_NEAR,   32'h8000_0000, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_BEFORE, 32'h0002_FFFF, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_BEFORE, 32'hFFFF_FFFF, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_FIND,   32'h0001_0000, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_FIND,   32'h0001_0001, 6'd0,  1, ST_NOT_FOUND, 32'h0, 6'd0, 7'd4);
    add_row(CMD_READ,   32'h0000_0000, 6'd3,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_READ,   32'h0000_0000, 6'd4,  1, ST_RANGE, 32'h0, 6'd0, 7'd4);
    add_row(CMD_REMOVE, 32'h0000_0000, 6'd0,  1, ST_OK, 32'h0000_0000, 6'd0, 7'd3);
    add_row(CMD_BEFORE, 32'h0000_8000, 6'd0,  1, ST_NOT_FOUND, 32'h0, 6'd0, 7'd3);
    add_row(CMD_NEAR,   32'h0000_0000, 6'd0,  0, ST_OK, 32'h0, 6'd0, 7'd0);
    add_row(CMD_SPARE,  32'hFFFF_FFFF, 6'd63, 1, ST_OK, 32'h0, 6'd0, 7'd3);
    add_row(CMD_CLEAR,  32'hFFFF_FFFF, 6'd63, 1, ST_OK, 32'h0, 6'd0, 7'd0);

    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].ts, dir_rows[i].idx, dir_rows[i].checked,
           dir_rows[i].want);

    // fill to capacity, then push past it
    while (held_count < SET_DEPTH) send(CMD_INSERT, $urandom, pick_pos(), 1'b0, '0);
    repeat (3) send(CMD_INSERT, $urandom, pick_pos(), 1'b0, '0);
    send(CMD_INSERT, held_stamps[$urandom_range(0, SET_DEPTH - 1)], 6'd0, 1'b0, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) mode = $urandom_range(0, 2);
      calm = (n >= 700 && n < 1000);
      if (n == 1300) begin
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      op = pick_cmd(mode);
      send(op, pick_stamp(), pick_pos(), 1'b0, '0);
    end

    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (bad_results == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
